[rtl/assert_macros.svh]
// assertion macros for the form pair decoder rtl
// expects i_clk and i_rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
// next-cycle implication
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMP(label, ante, cons)
`define ASSERT_NXT(label, ante, cons)
`endif
`endif

[rtl/ufp_pkg.sv]
// shared types, character constants and hex helper for the form pair decoder
// no dependencies
`timescale 1ns / 1ps

package ufp_pkg;

    localparam logic [7:0] C_NUL   = 8'h00;
    localparam logic [7:0] C_EQ    = 8'h3D;
    localparam logic [7:0] C_AMP   = 8'h26;
    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_PCT   = 8'h25;
    localparam logic [7:0] C_ZERO  = 8'h30;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_UPPER_A = 8'h41;
    localparam logic [7:0] C_LOWER_A = 8'h61;

    localparam logic [2:0] QUEUE_DEPTH = 3'd4;

    typedef enum logic [2:0] {
        PH_NAME  = 3'd0,
        PH_VALUE = 3'd1,
        PH_ESC1  = 3'd2,
        PH_ESC2  = 3'd3,
        PH_DONE  = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        K_NAME_CHAR  = 3'd0,
        K_VALUE_CHAR = 3'd1,
        K_NAME_END   = 3'd2,
        K_PAIR_END   = 3'd3,
        K_PARSE_END  = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] char_out;
        logic [7:0] pair_index;
        logic       last;
    } t_result;

    // results of one byte: count is 0, 1 or 2
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_step;

    // non-hex digits decode as zero
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c inside {[8'h30:8'h39]}) begin
                d = c - C_ZERO;
            end else if (c inside {[8'h41:8'h46]}) begin
                d = c - C_UPPER_A + 8'd10;
            end else if (c inside {[8'h61:8'h66]}) begin
                d = c - C_LOWER_A + 8'd10;
            end
            return d[3:0];
        end
    endfunction

endpackage

[rtl/ufp_core.sv]
// parse state machine: state registers and per-byte result generation
// depends on ufp_pkg
`timescale 1ns / 1ps

module ufp_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  logic [7:0]     i_byte,
    input  logic [7:0]     i_max_pairs,
    output ufp_pkg::t_step o_step
);
    import ufp_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_pair_count, n_pair_count;
    logic [3:0] r_escape_high, n_escape_high;

    logic [7:0] cnt_inc;
    logic       at_limit;
    logic [3:0] nib;
    t_step      step;

    assign cnt_inc  = (r_pair_count == 8'hFF) ? r_pair_count : r_pair_count + 8'd1;
    assign at_limit = (i_max_pairs != 8'd0) && (cnt_inc >= i_max_pairs);
    assign nib      = hex_nibble(i_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_NAME;
            r_pair_count  <= 8'd0;
            r_escape_high <= 4'd0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_pair_count  <= n_pair_count;
            r_escape_high <= n_escape_high;
        end
    end

    // next state
    always_comb begin
        n_phase       = r_phase;
        n_pair_count  = r_pair_count;
        n_escape_high = r_escape_high;
        if (i_byte == C_NUL) begin
            n_phase       = PH_NAME;
            n_pair_count  = 8'd0;
            n_escape_high = 4'd0;
        end else begin
            case (r_phase)
                PH_NAME: begin
                    if (i_byte == C_EQ) n_phase = PH_VALUE;
                end
                PH_VALUE: begin
                    if (i_byte == C_AMP) begin
                        n_pair_count = cnt_inc;
                        n_phase      = at_limit ? PH_DONE : PH_NAME;
                    end else if (i_byte == C_PCT) begin
                        n_phase = PH_ESC1;
                    end
                end
                PH_ESC1: begin
                    n_escape_high = nib;
                    n_phase       = PH_ESC2;
                end
                PH_ESC2: begin
                    n_escape_high = 4'd0;
                    n_phase       = PH_VALUE;
                end
                PH_DONE: ;
                default: n_phase = PH_NAME;
            endcase
        end
    end

    // results
    always_comb begin
        step = '0;
        step.r0.pair_index = r_pair_count;
        step.r1.pair_index = cnt_inc;
        step.r1.kind       = K_PARSE_END;
        case (r_phase)
            PH_NAME: begin
                step.count = 2'd1;
                if (i_byte == C_NUL) begin
                    step.r0.kind = K_PARSE_END;
                end else if (i_byte == C_EQ) begin
                    step.r0.kind = K_NAME_END;
                end else begin
                    step.r0.kind     = K_NAME_CHAR;
                    step.r0.char_out = i_byte;
                end
            end
            PH_VALUE: begin
                if (i_byte == C_NUL) begin
                    step.count   = 2'd2;
                    step.r0.kind = K_PAIR_END;
                end else if (i_byte == C_AMP) begin
                    step.count   = at_limit ? 2'd2 : 2'd1;
                    step.r0.kind = K_PAIR_END;
                end else if (i_byte == C_PLUS) begin
                    step.count       = 2'd1;
                    step.r0.kind     = K_VALUE_CHAR;
                    step.r0.char_out = C_SPACE;
                end else if (i_byte != C_PCT) begin
                    step.count       = 2'd1;
                    step.r0.kind     = K_VALUE_CHAR;
                    step.r0.char_out = i_byte;
                end
            end
            PH_ESC1: begin
                if (i_byte == C_NUL) begin
                    step.count   = 2'd2;
                    step.r0.kind = K_PAIR_END;
                end
            end
            PH_ESC2: begin
                step.count = 2'd1;
                if (i_byte == C_NUL) begin
                    step.count   = 2'd2;
                    step.r0.kind = K_PAIR_END;
                end else begin
                    step.r0.kind     = K_VALUE_CHAR;
                    step.r0.char_out = {r_escape_high, nib};
                end
            end
            PH_DONE: ;
            default: step.count = 2'd0;
        endcase
        step.r0.last = (step.count == 2'd1);
        step.r1.last = 1'b1;
    end

    assign o_step = step;

endmodule

[rtl/ufp_rqueue.sv]
// small result queue, up to two pushes and one pop per cycle
// depends on ufp_pkg
`timescale 1ns / 1ps

module ufp_rqueue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ufp_pkg::t_step   i_push,
    input  logic             i_pop,
    output ufp_pkg::t_result o_head,
    output logic [2:0]       o_count
);
    import ufp_pkg::*;

    t_result    r_mem [4];
    logic [1:0] r_wr_ptr, n_wr_ptr;
    logic [1:0] r_rd_ptr, n_rd_ptr;
    logic [2:0] r_count, n_count;
    logic [1:0] wr_next;

    assign wr_next  = r_wr_ptr + 2'd1;
    assign n_wr_ptr = r_wr_ptr + i_push.count;
    assign n_rd_ptr = r_rd_ptr + {1'b0, i_pop};
    assign n_count  = r_count - {2'b00, i_pop} + {1'b0, i_push.count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) r_mem[r_wr_ptr] <= i_push.r0;
        if (i_push.count == 2'd2) r_mem[wr_next]  <= i_push.r1;
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

[rtl/url_form_pair_decoder.sv]
// top level of the form pair decoder: input register, parse core, result queue
// depends on ufp_pkg, ufp_core, ufp_rqueue and assert_macros.svh
//
// streaming decoder for name=value&name=value strings, one byte per input
// transaction, a zero byte ends the string. each byte is caught in an input
// register, the parse core turns it into zero, one or two tagged results
// combinationally, and those land in a four-entry result queue that drives the
// output port. a byte is taken every cycle as long as the queue will have room
// for two results after this cycle's pop, so a stalled output does not block
// the input until the queue fills. sustained rate is one byte per cycle; bytes
// that make two results (pair end plus parse end) push both into the queue,
// so the output port, one result per cycle, sets the limit in that case. each
// accepted byte passes the input register, then the result queue, before its
// first result is visible. max_pairs is written through the configuration
// transaction port, which is always ready; write it only while the block idles
`timescale 1ns / 1ps
`include "assert_macros.svh"

module url_form_pair_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input byte channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_byte_in,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_kind,
    output logic [7:0] o_char_out,
    output logic [7:0] o_pair_index,
    output logic       o_last,
    // configuration write channel (max_pairs)
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);
    import ufp_pkg::*;

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic [7:0] r_max_pairs;

    t_step      step;
    t_step      push;
    t_result    head;
    logic [2:0] q_count;
    logic [2:0] count_after_pop;
    logic       pop;
    logic       fire;
    logic       load;

    // output side
    assign o_out_valid = (q_count != 3'd0);
    assign pop         = o_out_valid && !i_out_stall;

    // consume the held byte only when two slots are guaranteed free
    assign count_after_pop = q_count - {2'b00, pop};
    assign fire            = r_in_valid && (count_after_pop <= (QUEUE_DEPTH - 3'd2));

    // input register refills whenever it is empty or its byte moves on
    assign o_in_stall = r_in_valid && !fire;
    assign load       = i_in_valid && !o_in_stall;
    assign n_in_valid = load || (r_in_valid && !fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_in_byte <= i_byte_in;
    end

    // configuration register, always accepted
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_pairs <= 8'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_pairs <= i_cfg_data;
        end
    end

    ufp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_byte      (r_in_byte),
        .i_max_pairs (r_max_pairs),
        .o_step      (step)
    );

    // nothing is pushed unless the byte is actually consumed
    always_comb begin
        push = step;
        if (!fire) push.count = 2'd0;
    end

    ufp_rqueue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_count (q_count)
    );

    assign o_kind       = head.kind;
    assign o_char_out   = head.char_out;
    assign o_pair_index = head.pair_index;
    assign o_last       = head.last;

    // queue occupancy stays within its depth
    `ASSERT_IMP(a_queue_bound, 1'b1, q_count <= QUEUE_DEPTH)
    // parse end is always the final result of its byte
    `ASSERT_IMP(a_parse_end_last, o_out_valid && (o_kind == K_PARSE_END), o_last)
    // a pair end that is not final is followed directly by a parse end
    `ASSERT_NXT(a_pair_then_parse,
                pop && (o_kind == K_PAIR_END) && !o_last,
                o_out_valid && (o_kind == K_PARSE_END))
    // only character results carry a character
    `ASSERT_IMP(a_char_zero,
                o_out_valid && (o_kind != K_NAME_CHAR) && (o_kind != K_VALUE_CHAR),
                o_char_out == 8'd0)

endmodule

[dv/ufp_checker.sv]
// result checker for the form pair decoder: watches the byte, result and config channels
// keeps its own decoder state, predicts tagged results and compares them in order
// depends on ufp_pkg for the phase and kind enums and the result struct
`timescale 1ns / 1ps

module ufp_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_byte_in,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [2:0] i_kind,
    input  logic [7:0] i_char_out,
    input  logic [7:0] i_pair_index,
    input  logic       i_last,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [7:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);
    import ufp_pkg::*;

    t_phase     phase_q;
    logic [7:0] pairs_closed;
    logic [3:0] high_nibble;
    logic [7:0] pair_limit;
    int         fail_count = 0;

    t_result    expected_results[$];
    t_result    byte_results[$];

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    // non-hex characters give zero
    function automatic logic [3:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= C_ZERO && c < C_ZERO + 8'd10) begin
            v = c - C_ZERO;
        end else if (c >= C_UPPER_A && c < C_UPPER_A + 8'd6) begin
            v = c - C_UPPER_A + 8'd10;
        end else if (c >= C_LOWER_A && c < C_LOWER_A + 8'd6) begin
            v = c - C_LOWER_A + 8'd10;
        end
        return v[3:0];
    endfunction

    task automatic restart_parse();
        phase_q      = PH_NAME;
        pairs_closed = 8'h00;
        high_nibble  = 4'h0;
    endtask

    task automatic add_result(input t_kind k, input logic [7:0] ch);
        t_result r;
        r.kind       = k;
        r.char_out   = ch;
        r.pair_index = pairs_closed;
        r.last       = 1'b0;
        byte_results.push_back(r);
    endtask

    task automatic close_pair(input bit at_terminator);
        add_result(K_PAIR_END, 8'h00);
        if (pairs_closed != 8'hFF) begin
            pairs_closed++;
        end
        if (at_terminator) begin
            add_result(K_PARSE_END, 8'h00);
            restart_parse();
        end else if (pair_limit != 8'h00 && pairs_closed >= pair_limit) begin
            add_result(K_PARSE_END, 8'h00);
            phase_q = PH_DONE;
        end else begin
            phase_q = PH_NAME;
        end
    endtask

    task automatic decode_byte(input logic [7:0] c);
        t_result r;
        byte_results.delete();
        case (phase_q)
            PH_NAME: begin
                if (c == C_NUL) begin
                    add_result(K_PARSE_END, 8'h00);
                    restart_parse();
                end else if (c == C_EQ) begin
                    add_result(K_NAME_END, 8'h00);
                    phase_q = PH_VALUE;
                end else begin
                    add_result(K_NAME_CHAR, c);
                end
            end
            PH_VALUE: begin
                if (c == C_NUL) begin
                    close_pair(1'b1);
                end else if (c == C_AMP) begin
                    close_pair(1'b0);
                end else if (c == C_PLUS) begin
                    add_result(K_VALUE_CHAR, C_SPACE);
                end else if (c == C_PCT) begin
                    phase_q = PH_ESC1;
                end else begin
                    add_result(K_VALUE_CHAR, c);
                end
            end
            PH_ESC1: begin
                if (c == C_NUL) begin
                    close_pair(1'b1);
                end else begin
                    high_nibble = digit_value(c);
                    phase_q     = PH_ESC2;
                end
            end
            PH_ESC2: begin
                if (c == C_NUL) begin
                    close_pair(1'b1);
                end else begin
                    add_result(K_VALUE_CHAR, {high_nibble, digit_value(c)});
                    high_nibble = 4'h0;
                    phase_q     = PH_VALUE;
                end
            end
            default: begin
                // done: everything is swallowed, the terminator rearms silently
                if (c == C_NUL) begin
                    restart_parse();
                end
            end
        endcase
        if (byte_results.size() > 0) begin
            r = byte_results.pop_back();
            r.last = 1'b1;
            byte_results.push_back(r);
        end
        foreach (byte_results[i]) begin
            expected_results.push_back(byte_results[i]);
        end
    endtask

    task automatic check_result();
        t_result want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with nothing expected, kind", {5'd0, i_kind}, 8'h00);
        end else begin
            want = expected_results.pop_front();
            if (i_kind !== want.kind) begin
                report_mismatch("kind", {5'd0, i_kind}, {5'd0, want.kind});
            end
            if (i_char_out !== want.char_out) begin
                report_mismatch("char_out", i_char_out, want.char_out);
            end
            if (i_pair_index !== want.pair_index) begin
                report_mismatch("pair_index", i_pair_index, want.pair_index);
            end
            if (i_last !== want.last) begin
                report_mismatch("last", {7'd0, i_last}, {7'd0, want.last});
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_parse();
            pair_limit = 8'h00;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_result();
            end
            if (i_in_valid && !i_in_stall) begin
                decode_byte(i_byte_in);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                pair_limit = i_cfg_data;
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_count;
    end

endmodule

[dv/tb_top.sv]
// testbench top for the form pair decoder: clock, reset, byte stimulus,
// max_pairs writes, randomized output stalls and the final verdict
// depends on ufp_pkg, url_form_pair_decoder and ufp_checker
`timescale 1ns / 1ps

module tb_top;
    import ufp_pkg::*;

    localparam int TIMEOUT_NS = 5_000_000;
    localparam int SETTLE_CYCLES = 4;     // covers the input register and result queue delay with margin
    localparam int LONG_HOLD_CYCLES = 80;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] byte_in;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] kind;
    logic [7:0] char_out;
    logic [7:0] pair_index;
    logic       out_last;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;
    int         fail_count;
    int         pending;

    // bytes of the form string that is about to go out
    logic [7:0] form_bytes[$];
    bit         sender_steady = 1'b0;
    // set by the stimulus, cleared by the receiver once its long hold is over
    bit         hold_output = 1'b0;

    url_form_pair_decoder u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_byte_in    (byte_in),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_kind       (kind),
        .o_char_out   (char_out),
        .o_pair_index (pair_index),
        .o_last       (out_last),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data)
    );

    ufp_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_byte_in    (byte_in),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_kind       (kind),
        .i_char_out   (char_out),
        .i_pair_index (pair_index),
        .i_last       (out_last),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ordinary text byte: never a terminator or one of the form delimiters
    function automatic logic [7:0] pick_text_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(1, 255));
        end while (c == C_EQ || c == C_AMP || c == C_PCT || c == C_PLUS);
        return c;
    endfunction

    // hex digit in either letter case
    function automatic logic [7:0] pick_hex_digit();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10) begin
            return C_ZERO + 8'(r);
        end else if (r < 16) begin
            return C_UPPER_A + 8'(r - 10);
        end
        return C_LOWER_A + 8'(r - 16);
    endfunction

    // push the queued string one transaction at a time, with a random gap before each
    // byte; valid stays up after the last acceptance until the caller moves on
    task automatic send_form();
        int gap;
        foreach (form_bytes[i]) begin
            if ($urandom_range(0, 49) == 0) begin
                sender_steady = !sender_steady;
            end
            gap = sender_steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            byte_in  <= form_bytes[i];
            do @(posedge clk); while (in_stall);
        end
        form_bytes.delete();
    endtask

    // mostly well-formed name=value&... strings; a broken one may stop the name
    // early, cut an escape short or carry non-hex escape digits
    task automatic build_form(input bit broken);
        int n_pairs;
        int name_len;
        int val_len;
        int r;
        n_pairs = $urandom_range(0, 4);
        for (int p = 0; p < n_pairs; p++) begin
            name_len = $urandom_range(0, 4);
            repeat (name_len) form_bytes.push_back(pick_text_char());
            if (broken && $urandom_range(0, 5) == 0) begin
                form_bytes.push_back(C_NUL);
                return;
            end
            form_bytes.push_back(C_EQ);
            val_len = $urandom_range(0, 6);
            repeat (val_len) begin
                r = $urandom_range(0, 9);
                if (r < 4) begin
                    form_bytes.push_back(pick_text_char());
                end else if (r < 6) begin
                    form_bytes.push_back(C_PLUS);
                end else if (r == 6) begin
                    form_bytes.push_back(C_EQ);
                end else begin
                    form_bytes.push_back(C_PCT);
                    if (broken && $urandom_range(0, 3) == 0) begin
                        // terminator right after the percent or after one digit
                        if ($urandom_range(0, 1) == 1) begin
                            form_bytes.push_back(pick_hex_digit());
                        end
                        form_bytes.push_back(C_NUL);
                        return;
                    end
                    if (broken) begin
                        form_bytes.push_back(8'($urandom_range(1, 255)));
                        form_bytes.push_back(8'($urandom_range(1, 255)));
                    end else begin
                        form_bytes.push_back(pick_hex_digit());
                        form_bytes.push_back(pick_hex_digit());
                    end
                end
            end
            // trailing ampersand now and then closes the last pair before the end
            if (p < n_pairs - 1 || $urandom_range(0, 3) == 0) begin
                form_bytes.push_back(C_AMP);
            end
        end
        form_bytes.push_back(C_NUL);
    endtask

    // random mix: well-formed strings, broken strings and raw noise
    // noise may leave a string open across a max_pairs change
    task automatic run_random(input int budget);
        int sent;
        int r;
        sent = 0;
        while (sent < budget) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                build_form(1'b0);
            end else if (r < 85) begin
                build_form(1'b1);
            end else begin
                repeat ($urandom_range(1, 12)) begin
                    form_bytes.push_back(8'($urandom_range(0, 255)));
                end
                if ($urandom_range(0, 1) == 1) begin
                    form_bytes.push_back(C_NUL);
                end
            end
            sent += form_bytes.size();
            send_form();
        end
    endtask

    // max_pairs is only written with the block idle: input paused, every
    // expected result drained and SETTLE_CYCLES of wait for a byte that makes none
    task automatic set_pair_limit(input logic [7:0] limit);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= limit;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // receiver: random stall before each result transaction, calm stretches,
    // and a long hold on request so the result queue fills and stalls the input
    initial begin
        int  wait_cycles;
        bit  steady;
        steady = 1'b0;
        out_stall <= 1'b0;
        forever begin
            if (hold_output) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
            end else begin
                if ($urandom_range(0, 39) == 0) begin
                    steady = !steady;
                end
                wait_cycles = steady ? 0 : $urandom_range(0, 6);
                if (wait_cycles > 0) begin
                    out_stall <= 1'b1;
                    repeat (wait_cycles) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        byte_in   <= 8'h00;
        cfg_valid <= 1'b0;
        cfg_data  <= 8'h00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset limit: byte extremes, name end, '=' and '+' in a value,
        // escapes in both letter cases, non-hex high digit, pair end,
        // terminator in a name, after '%' and after the first escape digit
        form_bytes = '{"a", 8'hFF, C_EQ, C_EQ, C_PLUS, C_PCT, "4", "f",
                       C_PCT, C_AMP, "B", C_AMP, "b", C_NUL,
                       C_EQ, C_PCT, C_NUL,
                       C_EQ, C_PCT, "A", C_NUL};
        send_form();

        // limit of one: parse end right after the pair end, then the done
        // phase swallows bytes and the terminator rearms without a result
        set_pair_limit(8'd1);
        form_bytes = '{C_EQ, C_AMP, "x", C_AMP, C_NUL};
        send_form();

        set_pair_limit(8'd0);
        hold_output = 1'b1;
        run_random(200);

        set_pair_limit(8'd2);
        run_random(120);

        set_pair_limit(8'd255);
        hold_output = 1'b1;
        run_random(120);

        set_pair_limit(8'd1);
        run_random(80);

        set_pair_limit(8'($urandom_range(3, 20)));
        run_random(80);

        // unlimited parse with more pairs than the count can hold: saturates
        set_pair_limit(8'd0);
        hold_output = 1'b1;
        repeat (258) begin
            form_bytes.push_back(C_EQ);
            form_bytes.push_back(C_AMP);
        end
        form_bytes.push_back(C_NUL);
        send_form();

        // drain, then a short quiet window to catch stray results
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("url_form_pair_decoder verification clean");
        end else begin
            $display("url_form_pair_decoder verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("url_form_pair_decoder verification failed");
        $finish;
    end

endmodule
